/* rtl/biq_pkg.sv */
// Shared types, widths, register indexes and command structs of the biquad filter.
package biq_pkg;

  localparam int SAMPLE_WIDTH = 16;
  localparam int COEF_WIDTH   = 24;
  localparam int NORM_WIDTH   = COEF_WIDTH - 1;
  localparam int PROD_WIDTH   = SAMPLE_WIDTH + COEF_WIDTH;
  localparam int ACC_WIDTH    = PROD_WIDTH + 3;

  // The divider retires this many quotient bits per clock.
  localparam int DIV_BITS     = 2;
  localparam int DIV_CYCLES   = (ACC_WIDTH + DIV_BITS - 1) / DIV_BITS;
  localparam int MAG_WIDTH    = DIV_CYCLES * DIV_BITS;

  localparam int NUM_TERMS    = 5;
  localparam int CNT_WIDTH    = $clog2(DIV_CYCLES + 1);
  localparam int CFG_IDX_WIDTH = 3;

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic signed [COEF_WIDTH-1:0]   coef_t;
  typedef logic        [NORM_WIDTH-1:0]   norm_t;
  typedef logic signed [PROD_WIDTH-1:0]   prod_t;
  typedef logic signed [ACC_WIDTH-1:0]    acc_t;
  typedef logic        [MAG_WIDTH-1:0]    mag_t;
  typedef logic        [CFG_IDX_WIDTH-1:0] cfg_idx_t;
  typedef logic        [COEF_WIDTH-1:0]   cfg_data_t;
  typedef logic        [2:0]              term_t;
  typedef logic        [CNT_WIDTH-1:0]    cnt_t;

  localparam cfg_idx_t CFG_FEED_0 = 3'd0;
  localparam cfg_idx_t CFG_FEED_1 = 3'd1;
  localparam cfg_idx_t CFG_FEED_2 = 3'd2;
  localparam cfg_idx_t CFG_NORM   = 3'd3;
  localparam cfg_idx_t CFG_BACK_1 = 3'd4;
  localparam cfg_idx_t CFG_BACK_2 = 3'd5;

  localparam term_t TERM_B0 = 3'd0;
  localparam term_t TERM_B1 = 3'd1;
  localparam term_t TERM_B2 = 3'd2;
  localparam term_t TERM_A1 = 3'd3;
  localparam term_t TERM_A2 = 3'd4;

  localparam coef_t COEF_ONE = coef_t'(1 << (COEF_WIDTH - 4));
  localparam norm_t NORM_ONE = norm_t'(1 << (COEF_WIDTH - 4));

  localparam mag_t POS_MAX = mag_t'((64'd1 << (SAMPLE_WIDTH - 1)) - 64'd1);
  localparam mag_t NEG_MAX = mag_t'(64'd1 << (SAMPLE_WIDTH - 1));

  typedef struct packed {
    logic  load;
    logic  mul_en;
    term_t term;
    logic  acc_en;
    logic  div_start;
    logic  div_step;
    logic  finish;
  } cmd_t;

  typedef struct packed {
    logic out_blocked;
  } sts_t;

endpackage

/* rtl/biq_if.sv */
// Handshake channel interfaces for samples in, samples out and register writes.
interface biq_in_if;
  import biq_pkg::*;
  logic    valid;
  logic    ready;
  sample_t sample_in;
  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface biq_out_if;
  import biq_pkg::*;
  logic    valid;
  logic    ready;
  sample_t sample_out;
  logic    clipped;
  modport source (output valid, output sample_out, output clipped, input ready);
  modport sink   (input valid, input sample_out, input clipped, output ready);
endinterface

interface biq_cfg_if;
  import biq_pkg::*;
  logic      valid;
  logic      ready;
  cfg_idx_t  index;
  cfg_data_t data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/biq_ctrl.sv */
// Sequencer of the biquad: multiply-accumulate steps, serial divide and result hand-off.
module biq_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output biq_pkg::cmd_t cmd_o,
  input  biq_pkg::sts_t sts_i
);
  import biq_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MAC  = 3'd1;
  localparam logic [2:0] ST_LOAD = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  localparam cnt_t MAC_LAST = cnt_t'(NUM_TERMS);
  localparam cnt_t DIV_LAST = cnt_t'(DIV_CYCLES - 1);

  logic [2:0] state_q, state_d;
  cnt_t       cnt_q, cnt_d;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = ST_MAC;
        end
      end
      ST_MAC: begin
        // The product of step n is registered and added in the next step, n + 1.
        cmd_o.mul_en = (cnt_q < MAC_LAST);
        cmd_o.term   = term_t'(cnt_q);
        cmd_o.acc_en = (cnt_q != '0);
        cnt_d        = cnt_q + 1'b1;
        if (cnt_q == MAC_LAST) begin
          cnt_d   = '0;
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd_o.div_start = 1'b1;
        state_d         = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == DIV_LAST) begin
          cnt_d   = '0;
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!sts_i.out_blocked) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
        cnt_d   = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  a_mac_to_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MAC && cnt_q == MAC_LAST) |=> state_q == ST_LOAD)
    else $error("multiply-accumulate sequence did not hand over to the divider");

  a_div_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && cnt_q == DIV_LAST) |=> state_q == ST_DONE)
    else $error("divider did not finish after its last step");

  a_finish_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |-> !sts_i.out_blocked)
    else $error("result written while the output register still holds an item");

  a_cmd_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.load, cmd_o.div_start, cmd_o.div_step, cmd_o.finish}))
    else $error("conflicting datapath commands");

endmodule

/* rtl/biq_datapath.sv */
// Biquad datapath: registers, history, shared multiplier, accumulator, divider, saturation.
module biq_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  biq_pkg::cmd_t     cmd_i,
  output biq_pkg::sts_t     sts_o,
  input  biq_pkg::sample_t  sample_in_i,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  biq_pkg::cfg_idx_t cfg_index_i,
  input  biq_pkg::cfg_data_t cfg_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output biq_pkg::sample_t  sample_out_o,
  output logic              clipped_o
);
  import biq_pkg::*;

  coef_t   b0_q, b1_q, b2_q, a1_q, a2_q;
  norm_t   a0_q;
  sample_t x0_q, x1_q, x2_q, y1_q, y2_q;
  coef_t   coef_sel;
  sample_t samp_sel;
  prod_t   prod_q;
  logic    sub_q;
  acc_t    acc_q;
  logic [ACC_WIDTH-1:0] mag;
  logic    neg_q, zero_q;
  norm_t   rem_q, rem_d;
  mag_t    quo_q, quo_d;
  sample_t res_d;
  logic    clip_d;
  logic    out_valid_q;
  sample_t sample_out_q;
  logic    clipped_q;

  assign cfg_ready_o = 1'b1;

  // Coefficient registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b0_q <= COEF_ONE;
      b1_q <= COEF_ONE;
      b2_q <= COEF_ONE;
      a0_q <= NORM_ONE;
      a1_q <= COEF_ONE;
      a2_q <= COEF_ONE;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_FEED_0: b0_q <= coef_t'(cfg_data_i);
        CFG_FEED_1: b1_q <= coef_t'(cfg_data_i);
        CFG_FEED_2: b2_q <= coef_t'(cfg_data_i);
        CFG_NORM:   a0_q <= cfg_data_i[NORM_WIDTH-1:0];
        CFG_BACK_1: a1_q <= coef_t'(cfg_data_i);
        CFG_BACK_2: a2_q <= coef_t'(cfg_data_i);
        default: ;
      endcase
    end
  end

  // Sample history; x0 takes the sample when it is accepted, the rest shifts only when the result is written.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x0_q <= '0;
      x1_q <= '0;
      x2_q <= '0;
      y1_q <= '0;
      y2_q <= '0;
    end else begin
      if (cmd_i.load) begin
        x0_q <= sample_in_i;
      end
      if (cmd_i.finish) begin
        x2_q <= x1_q;
        x1_q <= x0_q;
        y2_q <= y1_q;
        y1_q <= res_d;
      end
    end
  end

  always_comb begin
    unique case (cmd_i.term)
      TERM_B0: begin coef_sel = b0_q; samp_sel = x0_q; end
      TERM_B1: begin coef_sel = b1_q; samp_sel = x1_q; end
      TERM_B2: begin coef_sel = b2_q; samp_sel = x2_q; end
      TERM_A1: begin coef_sel = a1_q; samp_sel = y1_q; end
      TERM_A2: begin coef_sel = a2_q; samp_sel = y2_q; end
      default: begin coef_sel = '0;   samp_sel = '0;   end
    endcase
  end

  // Restoring division of the magnitude, two quotient bits per cycle.
  always_comb begin
    logic [NORM_WIDTH:0] trial;
    norm_t rem;
    mag_t  quo;
    rem = rem_q;
    quo = quo_q;
    for (int k = 0; k < DIV_BITS; k++) begin
      trial = {rem, quo[MAG_WIDTH-1]};
      quo   = {quo[MAG_WIDTH-2:0], 1'b0};
      if (trial >= {1'b0, a0_q}) begin
        rem    = NORM_WIDTH'(trial - {1'b0, a0_q});
        quo[0] = 1'b1;
      end else begin
        rem = trial[NORM_WIDTH-1:0];
      end
    end
    rem_d = rem;
    quo_d = quo;
  end

  assign mag = acc_q[ACC_WIDTH-1] ? ACC_WIDTH'(-acc_q) : acc_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q <= prod_t'(coef_sel * samp_sel);
      sub_q  <= (cmd_i.term == TERM_A1) || (cmd_i.term == TERM_A2);
    end
    if (cmd_i.load) begin
      acc_q <= '0;
    end else if (cmd_i.acc_en) begin
      acc_q <= sub_q ? acc_q - ACC_WIDTH'(prod_q) : acc_q + ACC_WIDTH'(prod_q);
    end
    if (cmd_i.div_start) begin
      neg_q  <= acc_q[ACC_WIDTH-1];
      zero_q <= (acc_q == '0);
      rem_q  <= '0;
      quo_q  <= mag_t'(mag);
    end else if (cmd_i.div_step) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  // Saturation; a zero sum stays zero even when the divisor is zero.
  always_comb begin
    res_d  = '0;
    clip_d = 1'b0;
    if (zero_q) begin
      res_d = '0;
    end else if (neg_q) begin
      if (quo_q > NEG_MAX) begin
        res_d  = sample_t'(NEG_MAX);
        clip_d = 1'b1;
      end else begin
        res_d = sample_t'(0) - sample_t'(quo_q[SAMPLE_WIDTH-1:0]);
      end
    end else begin
      if (quo_q > POS_MAX) begin
        res_d  = sample_t'(POS_MAX);
        clip_d = 1'b1;
      end else begin
        res_d = sample_t'(quo_q[SAMPLE_WIDTH-1:0]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      sample_out_q <= res_d;
      clipped_q    <= clip_d;
    end
  end

  assign sts_o.out_blocked = out_valid_q && !out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign sample_out_o      = sample_out_q;
  assign clipped_o         = clipped_q;

endmodule

/* rtl/biquad_iir_filter.sv */
// Top level of the direct form I biquad filter with divide and saturation.
//
//   channel      dir  handshake      payload
//   in_chan_i    in   valid/ready    sample_in (signed 16)
//   out_chan_o   out  valid/ready    sample_out (signed 16), clipped
//   cfg_chan_i   in   valid/ready    index (3), data (24); ready is always high
//
// Each item passes in order through the idle state that accepts it, the steps on
// the shared 16x24 multiplier and accumulator, a divider load, the two-bit-per-cycle
// restoring divider and a write state; the next item is accepted only after that.
// The result sits in an output register; a stalled output holds the finished item
// in the write cycle until the register frees. Reset sets all coefficients to 1.0
// and clears the sample history.
module biquad_iir_filter (
  input  logic       clk_i,
  input  logic       rst_ni,
  biq_in_if.sink     in_chan_i,
  biq_out_if.source  out_chan_o,
  biq_cfg_if.sink    cfg_chan_i
);
  import biq_pkg::*;

  cmd_t cmd;
  sts_t sts;

  biq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_chan_i.valid),
    .in_ready_o (in_chan_i.ready),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  biq_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .sample_in_i  (in_chan_i.sample_in),
    .cfg_valid_i  (cfg_chan_i.valid),
    .cfg_ready_o  (cfg_chan_i.ready),
    .cfg_index_i  (cfg_chan_i.index),
    .cfg_data_i   (cfg_chan_i.data),
    .out_valid_o  (out_chan_o.valid),
    .out_ready_i  (out_chan_o.ready),
    .sample_out_o (out_chan_o.sample_out),
    .clipped_o    (out_chan_o.clipped)
  );

endmodule
